FILE: hw/rtl/chained_hash_set_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the chained hash set unit
// Wraps concurrent assertions on clk_i with reset rst_ni; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_SET_UNIT_ASSERT_SVH
`define CHAINED_HASH_SET_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define CHS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("chained hash set: assertion failed");
`define CHS_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("chained hash set: implication failed");
`else
`define CHS_ASSERT(lbl, prop)
`define CHS_ASSERT_IMPL(lbl, pre, post)
`endif
`endif

FILE: hw/rtl/chs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_pkg
// Sizes, codes and types shared by the chained hash set unit.
// ----------------------------------------------------------------------------
package chs_pkg;

  localparam int unsigned BUCKETS      = 100;
  localparam int unsigned BUCKET_DEPTH = 8;

  localparam int unsigned KEY_W     = 31;
  localparam int unsigned TOTAL_W   = 10;
  localparam int unsigned BUCKET_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned SLOT_W    = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int unsigned FILL_W    = $clog2(BUCKET_DEPTH + 1);
  localparam int unsigned ADDR_W    = BUCKET_W + SLOT_W;
  localparam int unsigned KEY_DEPTH = BUCKETS << SLOT_W;

  // floor(2^KEY_W / BUCKETS): quotient estimate is exact or one low
  localparam logic [KEY_W-1:0] BUCKET_RECIP = KEY_W'((64'd1 << KEY_W) / BUCKETS);

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_SEARCH = 1'b1
  } chs_func_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_FILL,
    ST_SCAN,
    ST_DONE
  } chs_state_e;

  typedef struct packed {
    logic                valid;
    logic [BUCKET_W-1:0] bucket;
  } chs_hash_t;

endpackage

FILE: hw/rtl/chs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_if
// Valid/ready channels: request items in, result items out.
// ----------------------------------------------------------------------------
interface chs_item_if;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [chs_pkg::KEY_W-1:0]  key;

  modport source (output valid, output func, output key, input ready);
  modport sink   (input valid, input func, input key, output ready);
endinterface

interface chs_result_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic                         full_res;
  logic [chs_pkg::TOTAL_W-1:0]  stored_total;

  modport source (output valid, output found, output full_res, output stored_total,
                  input ready);
  modport sink   (input valid, input found, input full_res, input stored_total,
                  output ready);
endinterface

FILE: hw/rtl/chs_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_hash
// Three-stage key modulo BUCKETS: reciprocal multiply, back-multiply,
// subtract with one correction step.
// ----------------------------------------------------------------------------
`include "chained_hash_set_unit_assert.svh"

module chs_hash (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [chs_pkg::KEY_W-1:0]      key_i,
  output chs_pkg::chs_hash_t             hash_o
);

  localparam int unsigned PROD_W = 2 * chs_pkg::KEY_W;

  logic [2:0]                      vld_q;
  logic [chs_pkg::KEY_W-1:0]       key1_q, key2_q;
  logic [PROD_W-1:0]               prod_q;
  logic [chs_pkg::KEY_W-1:0]       qd_q;
  logic [chs_pkg::BUCKET_W-1:0]    bucket_q;

  logic [chs_pkg::KEY_W-1:0]       quot;
  logic [chs_pkg::KEY_W-1:0]       rem;
  logic [chs_pkg::BUCKET_W-1:0]    bucket_d;

  assign quot = prod_q[PROD_W-1:chs_pkg::KEY_W];
  assign rem  = key2_q - qd_q;

  always_comb begin
    if (rem >= chs_pkg::KEY_W'(chs_pkg::BUCKETS)) begin
      bucket_d = chs_pkg::BUCKET_W'(rem - chs_pkg::KEY_W'(chs_pkg::BUCKETS));
    end else begin
      bucket_d = chs_pkg::BUCKET_W'(rem);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    key1_q   <= key_i;
    prod_q   <= PROD_W'(key_i) * PROD_W'(chs_pkg::BUCKET_RECIP);
    key2_q   <= key1_q;
    qd_q     <= quot * chs_pkg::KEY_W'(chs_pkg::BUCKETS);
    bucket_q <= bucket_d;
  end

  assign hash_o.valid  = vld_q[2];
  assign hash_o.bucket = bucket_q;

  `CHS_ASSERT_IMPL(a_bucket_range, hash_o.valid,
                   chs_pkg::KEY_W'(hash_o.bucket) < chs_pkg::KEY_W'(chs_pkg::BUCKETS))
  `CHS_ASSERT_IMPL(a_rem_range, vld_q[1],
                   (key2_q - qd_q) < chs_pkg::KEY_W'(2 * chs_pkg::BUCKETS))
  `CHS_ASSERT_IMPL(a_latency, hash_o.valid, $past(start_i, 3))

endmodule

FILE: hw/rtl/chained_hash_set_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_set_unit
// Hash set of 31-bit keys in BUCKETS fixed buckets of BUCKET_DEPTH slots.
// ----------------------------------------------------------------------------
// Usage: after reset the unit clears its bucket fill counts, one bucket per
// cycle, and holds item_i.ready low until all BUCKETS (100) buckets are
// cleared. It then works on one item at a time. An insert reads the bucket
// fill count after the hash and writes the key if there is room; a search
// then runs the bucket scan, which reads the key memory one slot per cycle
// and compares up to BUCKET_DEPTH (8) stored keys, stopping at a match.
// A finished result waits in the output register while the next item is
// taken; inserts into a full bucket are dropped and flagged by full_res.
`include "chained_hash_set_unit_assert.svh"

module chained_hash_set_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  chs_item_if.sink       item_i,
  chs_result_if.source   result_o
);

  chs_pkg::chs_state_e state_q, state_d;

  chs_pkg::chs_func_e                func_q, func_d;
  logic [chs_pkg::KEY_W-1:0]         key_q, key_d;
  logic [chs_pkg::BUCKET_W-1:0]      bucket_q, bucket_d;
  logic [chs_pkg::FILL_W-1:0]        fill_q, fill_d;
  logic [chs_pkg::FILL_W-1:0]        scan_idx_q, scan_idx_d;
  logic                              found_q, found_d;
  logic                              full_q, full_d;
  logic [chs_pkg::TOTAL_W-1:0]       total_q, total_d;
  logic [chs_pkg::BUCKET_W-1:0]      clr_idx_q, clr_idx_d;

  logic                              out_valid_q, out_valid_d;
  logic                              out_found_q, out_found_d;
  logic                              out_full_q, out_full_d;
  logic [chs_pkg::TOTAL_W-1:0]       out_total_q, out_total_d;

  logic                              item_acc;
  logic                              out_free;
  chs_pkg::chs_hash_t                hash;

  // key slot memory, {bucket, slot} addressed
  logic [chs_pkg::KEY_W-1:0]         key_mem [chs_pkg::KEY_DEPTH];
  logic                              key_we, key_re;
  logic [chs_pkg::ADDR_W-1:0]        key_waddr, key_raddr;
  logic [chs_pkg::KEY_W-1:0]         key_rdata_q;

  // bucket fill count memory
  logic [chs_pkg::FILL_W-1:0]        fill_mem [chs_pkg::BUCKETS];
  logic                              fill_we, fill_re;
  logic [chs_pkg::BUCKET_W-1:0]      fill_waddr, fill_raddr;
  logic [chs_pkg::FILL_W-1:0]        fill_wdata;
  logic [chs_pkg::FILL_W-1:0]        fill_rdata_q;

  assign item_i.ready = (state_q == chs_pkg::ST_IDLE);
  assign item_acc     = item_i.valid && item_i.ready;
  assign out_free     = !out_valid_q || result_o.ready;

  chs_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (item_acc),
    .key_i   (item_i.key),
    .hash_o  (hash)
  );

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_q;
    end
    if (key_re) begin
      key_rdata_q <= key_mem[key_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fill_we) begin
      fill_mem[fill_waddr] <= fill_wdata;
    end
    if (fill_re) begin
      fill_rdata_q <= fill_mem[fill_raddr];
    end
  end

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    key_d       = key_q;
    bucket_d    = bucket_q;
    fill_d      = fill_q;
    scan_idx_d  = scan_idx_q;
    found_d     = found_q;
    full_d      = full_q;
    total_d     = total_q;
    clr_idx_d   = clr_idx_q;
    out_found_d = out_found_q;
    out_full_d  = out_full_q;
    out_total_d = out_total_q;
    out_valid_d = out_valid_q && !result_o.ready;

    key_we     = 1'b0;
    key_re     = 1'b0;
    key_waddr  = {bucket_q, fill_rdata_q[chs_pkg::SLOT_W-1:0]};
    fill_we    = 1'b0;
    fill_re    = 1'b0;
    fill_waddr = bucket_q;
    fill_wdata = fill_rdata_q + chs_pkg::FILL_W'(1);
    fill_raddr = hash.bucket;

    case (state_q)
      chs_pkg::ST_CLEAR: begin
        fill_we    = 1'b1;
        fill_waddr = clr_idx_q;
        fill_wdata = '0;
        if (clr_idx_q == chs_pkg::BUCKET_W'(chs_pkg::BUCKETS - 1)) begin
          state_d = chs_pkg::ST_IDLE;
        end else begin
          clr_idx_d = clr_idx_q + chs_pkg::BUCKET_W'(1);
        end
      end
      chs_pkg::ST_IDLE: begin
        if (item_acc) begin
          func_d  = chs_pkg::chs_func_e'(item_i.func);
          key_d   = item_i.key;
          state_d = chs_pkg::ST_HASH;
        end
      end
      chs_pkg::ST_HASH: begin
        if (hash.valid) begin
          bucket_d = hash.bucket;
          fill_re  = 1'b1;
          state_d  = chs_pkg::ST_FILL;
        end
      end
      chs_pkg::ST_FILL: begin
        fill_d  = fill_rdata_q;
        found_d = 1'b0;
        full_d  = 1'b0;
        state_d = chs_pkg::ST_DONE;
        if (func_q == chs_pkg::FUNC_INSERT) begin
          if (fill_rdata_q >= chs_pkg::FILL_W'(chs_pkg::BUCKET_DEPTH)) begin
            full_d = 1'b1;
          end else begin
            key_we  = 1'b1;
            fill_we = 1'b1;
            total_d = total_q + chs_pkg::TOTAL_W'(1);
          end
        end else if (fill_rdata_q != '0) begin
          scan_idx_d = '0;
          key_re     = 1'b1;
          state_d    = chs_pkg::ST_SCAN;
        end
      end
      chs_pkg::ST_SCAN: begin
        if (key_rdata_q == key_q) begin
          found_d = 1'b1;
          state_d = chs_pkg::ST_DONE;
        end else if (scan_idx_q + chs_pkg::FILL_W'(1) == fill_q) begin
          state_d = chs_pkg::ST_DONE;
        end else begin
          scan_idx_d = scan_idx_q + chs_pkg::FILL_W'(1);
          key_re     = 1'b1;
        end
      end
      chs_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_found_d = found_q;
          out_full_d  = full_q;
          out_total_d = total_q;
          state_d     = chs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = chs_pkg::ST_IDLE;
      end
    endcase

    key_raddr = {bucket_q, scan_idx_d[chs_pkg::SLOT_W-1:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= chs_pkg::ST_CLEAR;
      clr_idx_q   <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q      <= func_d;
    key_q       <= key_d;
    bucket_q    <= bucket_d;
    fill_q      <= fill_d;
    scan_idx_q  <= scan_idx_d;
    found_q     <= found_d;
    full_q      <= full_d;
    out_found_q <= out_found_d;
    out_full_q  <= out_full_d;
    out_total_q <= out_total_d;
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.found        = out_found_q;
  assign result_o.full_res     = out_full_q;
  assign result_o.stored_total = out_total_q;

  `CHS_ASSERT_IMPL(a_fill_bound, state_q == chs_pkg::ST_FILL,
                   fill_rdata_q <= chs_pkg::FILL_W'(chs_pkg::BUCKET_DEPTH))
  `CHS_ASSERT_IMPL(a_scan_bound, state_q == chs_pkg::ST_SCAN, scan_idx_q < fill_q)
  `CHS_ASSERT_IMPL(a_total_step, total_q != $past(total_q),
                   $past(state_q == chs_pkg::ST_FILL && func_q == chs_pkg::FUNC_INSERT))

endmodule
